// File: src/ttoi_pkg.sv
// ----------------------------------------------------------------------------
// ttoi_pkg
// Shared types and constants for the streaming text-to-integer converter.
// ----------------------------------------------------------------------------
package ttoi_pkg;

    localparam longint unsigned TTOI_COUNT_LIMIT = 64'd65535;
    localparam logic [63:0]     TTOI_MAG_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [5:0] TTOI_BASE_AUTO = 6'd0;
    localparam logic [5:0] TTOI_BASE_OCT  = 6'd8;
    localparam logic [5:0] TTOI_BASE_DEC  = 6'd10;
    localparam logic [5:0] TTOI_BASE_HEX  = 6'd16;

    localparam logic [7:0] TTOI_CH_SPACE = 8'h20;
    localparam logic [7:0] TTOI_CH_TAB   = 8'h09;
    localparam logic [7:0] TTOI_CH_CR    = 8'h0D;
    localparam logic [7:0] TTOI_CH_PLUS  = 8'h2B;
    localparam logic [7:0] TTOI_CH_MINUS = 8'h2D;
    localparam logic [7:0] TTOI_CH_0     = 8'h30;
    localparam logic [7:0] TTOI_CH_9     = 8'h39;
    localparam logic [7:0] TTOI_CH_UA    = 8'h41;
    localparam logic [7:0] TTOI_CH_UZ    = 8'h5A;
    localparam logic [7:0] TTOI_CH_LA    = 8'h61;
    localparam logic [7:0] TTOI_CH_LZ    = 8'h7A;
    localparam logic [7:0] TTOI_CH_UX    = 8'h58;
    localparam logic [7:0] TTOI_CH_LX    = 8'h78;
    localparam logic [7:0] TTOI_LETTER_OFS = 8'd10;

    // classified character, front to back
    typedef struct packed {
        logic       start;
        logic [5:0] base;
        logic       is_ws;
        logic       is_sign;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
        logic       is_digit;
        logic [5:0] digit;
    } ttoi_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ttoi_qstat_t;

endpackage

// File: src/text_to_integer_any_base.sv
// ----------------------------------------------------------------------------
// text_to_integer_any_base
// Streaming strtol-style converter: one character per cycle in while in_stall
// is low, one result per conversion out at the first character that is not a
// digit of the base. The stopping character passes the two-entry queue and
// then the result register. Each digit takes a 64x6 multiply-add.
// Reset: async, clears the queue, the conversion state and the result valid.
// ----------------------------------------------------------------------------
module text_to_integer_any_base
    import ttoi_pkg::*;
#(
    parameter longint unsigned COUNT_LIMIT = TTOI_COUNT_LIMIT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         ch,
    input  logic               start_req,
    input  logic [5:0]         base,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] value,
    output logic [15:0]        consumed,
    output logic               overflow
);

    ttoi_item_t  f_item;
    ttoi_item_t  q_item;
    ttoi_qstat_t q_stat;
    logic        q_push;
    logic        q_pop;

    assign in_stall = q_stat.full;
    assign q_push   = in_valid && !q_stat.full;

    ttoi_front u_front (
        .ch        (ch),
        .start_req (start_req),
        .base      (base),
        .item      (f_item)
    );

    ttoi_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (f_item),
        .pop     (q_pop),
        .rd_item (q_item),
        .stat    (q_stat)
    );

    ttoi_back #(
        .COUNT_LIMIT (COUNT_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (!q_stat.empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .consumed  (consumed),
        .overflow  (overflow)
    );

    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !q_stat.empty)
        else $error("accepted character not in queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (64'(consumed) <= COUNT_LIMIT) || (consumed == 16'hFFFF))
        else $error("consumed count beyond limit");

endmodule

// File: src/ttoi_front.sv
// ----------------------------------------------------------------------------
// ttoi_front
// Character classifier: whitespace, sign, prefix characters and digit value.
// ----------------------------------------------------------------------------
module ttoi_front
    import ttoi_pkg::*;
(
    input  logic [7:0]  ch,
    input  logic        start_req,
    input  logic [5:0]  base,
    output ttoi_item_t  item
);

    logic       is_num;
    logic       is_up;
    logic       is_lo;
    logic [7:0] d_num;
    logic [7:0] d_up;
    logic [7:0] d_lo;

    always_comb
    begin
        is_num = (ch >= TTOI_CH_0) && (ch <= TTOI_CH_9);
        is_up  = (ch >= TTOI_CH_UA) && (ch <= TTOI_CH_UZ);
        is_lo  = (ch >= TTOI_CH_LA) && (ch <= TTOI_CH_LZ);
        d_num  = ch - TTOI_CH_0;
        d_up   = ch - TTOI_CH_UA + TTOI_LETTER_OFS;
        d_lo   = ch - TTOI_CH_LA + TTOI_LETTER_OFS;

        item.start    = start_req;
        item.base     = base;
        item.is_ws    = (ch == TTOI_CH_SPACE) || ((ch >= TTOI_CH_TAB) && (ch <= TTOI_CH_CR));
        item.is_sign  = (ch == TTOI_CH_PLUS) || (ch == TTOI_CH_MINUS);
        item.is_minus = (ch == TTOI_CH_MINUS);
        item.is_zero  = (ch == TTOI_CH_0);
        item.is_x     = (ch == TTOI_CH_UX) || (ch == TTOI_CH_LX);
        item.is_digit = is_num || is_up || is_lo;
        priority if (is_num)
            item.digit = d_num[5:0];
        else if (is_up)
            item.digit = d_up[5:0];
        else
            item.digit = d_lo[5:0];
    end

endmodule

// File: src/ttoi_queue.sv
// ----------------------------------------------------------------------------
// ttoi_queue
// Two-entry queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module ttoi_queue
    import ttoi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  ttoi_item_t  wr_item,
    input  logic        pop,
    output ttoi_item_t  rd_item,
    output ttoi_qstat_t stat
);

    ttoi_item_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        rd_item     = mem_reg[rd_ptr_reg];
        stat.full   = (count_reg == 2'd2);
        stat.empty  = (count_reg == 2'd0);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/ttoi_back.sv
// ----------------------------------------------------------------------------
// ttoi_back
// Conversion sequencer: sign, prefix, digit multiply-add and result register.
// ----------------------------------------------------------------------------
module ttoi_back
    import ttoi_pkg::*;
#(
    parameter longint unsigned COUNT_LIMIT = TTOI_COUNT_LIMIT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  ttoi_item_t         q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] value,
    output logic [15:0]        consumed,
    output logic               overflow
);

    localparam logic [15:0] COUNT_CAP =
        (COUNT_LIMIT < 64'd65535) ? COUNT_LIMIT[15:0] : 16'hFFFF;

    typedef enum logic [4:0] {
        PH_DONE   = 5'b00001,
        PH_LEAD   = 5'b00010,
        PH_PRE    = 5'b00100,
        PH_ZERO   = 5'b01000,
        PH_DIGITS = 5'b10000
    } ttoi_phase_t;

    ttoi_phase_t phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic [5:0]  base_reg, base_next;
    logic [63:0] acc_reg, acc_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        ovf_reg, ovf_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [63:0] value_reg, value_next;
    logic [15:0]        consumed_reg, consumed_next;
    logic               overflow_reg, overflow_next;

    logic        bump;
    logic        emit;
    logic        run_pre;
    logic        run_zero;
    logic        run_dig;
    logic [70:0] prod;

    assign q_pop = q_valid && !(out_valid_reg && out_stall);

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        bump       = 1'b0;
        emit       = 1'b0;
        run_pre    = 1'b0;
        run_zero   = 1'b0;
        run_dig    = 1'b0;
        prod       = '0;

        if (q_item.start)
        begin
            phase_next = PH_LEAD;
            neg_next   = 1'b0;
            base_next  = q_item.base;
            acc_next   = '0;
            cnt_next   = '0;
            ovf_next   = 1'b0;
        end

        unique case (phase_next)
            PH_LEAD:
            begin
                if (q_item.is_ws)
                    bump = 1'b1;
                else if (q_item.is_sign)
                begin
                    neg_next   = q_item.is_minus;
                    bump       = 1'b1;
                    phase_next = PH_PRE;
                end
                else
                    run_pre = 1'b1;
            end
            PH_PRE:    run_pre  = 1'b1;
            PH_ZERO:   run_zero = 1'b1;
            PH_DIGITS: run_dig  = 1'b1;
            default:   ;
        endcase

        if (run_pre)
        begin
            if ((base_next == TTOI_BASE_AUTO || base_next == TTOI_BASE_HEX) && q_item.is_zero)
            begin
                bump       = 1'b1;
                phase_next = PH_ZERO;
            end
            else
            begin
                if (base_next == TTOI_BASE_AUTO)
                    base_next = TTOI_BASE_DEC;
                phase_next = PH_DIGITS;
                run_dig    = 1'b1;
            end
        end

        if (run_zero)
        begin
            phase_next = PH_DIGITS;
            if (q_item.is_x)
            begin
                base_next = TTOI_BASE_HEX;
                bump      = 1'b1;
            end
            else
            begin
                if (base_next == TTOI_BASE_AUTO)
                    base_next = TTOI_BASE_OCT;
                run_dig = 1'b1;
            end
        end

        if (run_dig)
        begin
            if (q_item.is_digit && (q_item.digit < base_next))
            begin
                prod = 71'(acc_next) * 71'(base_next) + 71'(q_item.digit);
                if (prod > 71'(TTOI_MAG_MAX))
                    ovf_next = 1'b1;
                acc_next = prod[63:0];
                bump     = 1'b1;
            end
            else
            begin
                emit       = 1'b1;
                phase_next = PH_DONE;
            end
        end

        if (bump && (cnt_next < COUNT_CAP))
            cnt_next = cnt_next + 16'd1;
    end

    always_comb
    begin
        value_next     = value_reg;
        consumed_next  = consumed_reg;
        overflow_next  = overflow_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (q_pop && emit)
        begin
            out_valid_next = 1'b1;
            value_next     = neg_next ? -$signed(acc_next) : $signed(acc_next);
            consumed_next  = cnt_next;
            overflow_next  = ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DONE;
            neg_reg       <= 1'b0;
            base_reg      <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                base_reg  <= base_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                ovf_reg   <= ovf_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        consumed_reg <= consumed_next;
        overflow_reg <= overflow_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign consumed  = consumed_reg;
    assign overflow  = overflow_reg;

endmodule

// File: verif/text_to_integer_any_base_tb.sv
// ----------------------------------------------------------------------------
// text_to_integer_any_base_tb
// Self-checking bench for the streaming text-to-integer converter. Characters
// are sent one request at a time under random sender gaps and receiver
// stalls. A behavioral model of the scanner predicts each conversion result,
// and every result the block returns is compared field by field against the
// oldest prediction. Directed tests cover whitespace, signs, prefixes, odd
// bases, overflow, aborts and count saturation. A random phase and a long
// receiver hold-off follow.
// ----------------------------------------------------------------------------
module text_to_integer_any_base_tb
    import ttoi_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          RANDOM_CHARS = 2000;
    localparam logic [15:0] COUNT_CAP    = (TTOI_COUNT_LIMIT < 64'd65535) ?
                                           16'(TTOI_COUNT_LIMIT) : 16'hFFFF;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LEAD   = 5'b00010,
        ST_PREFIX = 5'b00100,
        ST_ZERO   = 5'b01000,
        ST_DIGITS = 5'b10000
    } scan_state_t;

    typedef struct packed {
        logic [63:0] value;
        logic [15:0] count;
        logic        ovf;
    } conv_result_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [7:0]         ch        = 8'h00;
    logic               start_req = 1'b0;
    logic [5:0]         base      = 6'd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [63:0] value;
    logic [15:0]        consumed;
    logic               overflow;

    // scanner model state
    scan_state_t  scan_st  = ST_IDLE;
    logic         neg_sign = 1'b0;
    logic [5:0]   run_base = 6'd0;
    logic [63:0]  magnitude = 64'd0;
    logic [15:0]  char_cnt = 16'd0;
    logic         mag_ovf  = 1'b0;

    conv_result_t pending_results[$];

    int  fail_count    = 0;
    int  cycles        = 0;
    int  chars_sent    = 0;
    int  results_seen  = 0;
    int  ovf_seen      = 0;
    int  hold_left     = 0;
    int  rx_wait       = 0;
    bit  tx_idle       = 1'b1;
    bit  rx_idle       = 1'b1;
    bit  lead_flag     = 1'b0;

    text_to_integer_any_base uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .start_req (start_req),
        .base      (base),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .consumed  (consumed),
        .overflow  (overflow)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left--;
    end

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        fail_count++;
        if (fail_count <= 40)
            $display("mismatch %s: got %0h expected %0h (result %0d, cycle %0d)",
                     what, got, want, results_seen, cycles);
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        conv_result_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_results.size() == 0)
                report("unexpected request", value, 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (value !== want.value)
                    report("value", value, want.value);
                if (consumed !== want.count)
                    report("consumed", 64'(consumed), 64'(want.count));
                if (overflow !== want.ovf)
                    report("overflow", 64'(overflow), 64'(want.ovf));
                if (want.ovf)
                    ovf_seen++;
            end
            results_seen++;
            rx_wait = rx_idle ? $urandom_range(0, 3) : 0;
        end
        out_stall <= (hold_left > 0) || (rx_wait > 0);
        if (rx_wait > 0)
            rx_wait--;
    end

    function automatic logic [6:0] digit_value(input logic [7:0] c);
        if (c >= TTOI_CH_0 && c <= TTOI_CH_9)
            return 7'(c - TTOI_CH_0);
        if (c >= TTOI_CH_UA && c <= TTOI_CH_UZ)
            return 7'(c - TTOI_CH_UA + TTOI_LETTER_OFS);
        if (c >= TTOI_CH_LA && c <= TTOI_CH_LZ)
            return 7'(c - TTOI_CH_LA + TTOI_LETTER_OFS);
        return 7'd64;
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == TTOI_CH_SPACE || (c >= TTOI_CH_TAB && c <= TTOI_CH_CR);
    endfunction

    task automatic bump_count();
        if (char_cnt < COUNT_CAP)
            char_cnt++;
    endtask

    task automatic predict_char(input logic [7:0] c, input logic s,
                                input logic [5:0] b);
        logic [6:0]   d;
        conv_result_t r;
        if (s)
        begin
            scan_st   = ST_LEAD;
            neg_sign  = 1'b0;
            run_base  = b;
            magnitude = 64'd0;
            char_cnt  = 16'd0;
            mag_ovf   = 1'b0;
        end
        if (scan_st == ST_IDLE)
            return;
        if (scan_st == ST_LEAD)
        begin
            if (is_space(c))
            begin
                bump_count();
                return;
            end
            if (c == TTOI_CH_PLUS || c == TTOI_CH_MINUS)
            begin
                neg_sign = (c == TTOI_CH_MINUS);
                bump_count();
                scan_st = ST_PREFIX;
                return;
            end
            scan_st = ST_PREFIX;
        end
        if (scan_st == ST_PREFIX)
        begin
            if ((run_base == TTOI_BASE_AUTO || run_base == TTOI_BASE_HEX) &&
                c == TTOI_CH_0)
            begin
                bump_count();
                scan_st = ST_ZERO;
                return;
            end
            if (run_base == TTOI_BASE_AUTO)
                run_base = TTOI_BASE_DEC;
            scan_st = ST_DIGITS;
        end
        else if (scan_st == ST_ZERO)
        begin
            if (c == TTOI_CH_UX || c == TTOI_CH_LX)
            begin
                run_base = TTOI_BASE_HEX;
                bump_count();
                scan_st = ST_DIGITS;
                return;
            end
            if (run_base == TTOI_BASE_AUTO)
                run_base = TTOI_BASE_OCT;
            scan_st = ST_DIGITS;
        end
        d = digit_value(c);
        if (d < {1'b0, run_base})
        begin
            if (magnitude > (TTOI_MAG_MAX - 64'(d)) / 64'(run_base))
                mag_ovf = 1'b1;
            magnitude = magnitude * 64'(run_base) + 64'(d);
            bump_count();
            return;
        end
        r.value = neg_sign ? (64'd0 - magnitude) : magnitude;
        r.count = char_cnt;
        r.ovf   = mag_ovf;
        pending_results.push_back(r);
        scan_st = ST_IDLE;
    endtask

    task automatic send_char(input logic [7:0] c, input logic s, input logic [5:0] b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        ch        <= c;
        start_req <= s;
        base      <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_char(c, s, b);
        chars_sent++;
    endtask

    // sends the text with start on its first character, then a NUL
    task automatic send_text(input string s, input logic [5:0] b);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == 0, b);
        send_char(8'h00, s.len() == 0, b);
    endtask

    task automatic emit(input logic [7:0] c, input logic [5:0] b);
        send_char(c, lead_flag, lead_flag ? b : 6'($urandom_range(0, 63)));
        lead_flag = 1'b0;
    endtask

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10)
            return 8'(TTOI_CH_0 + v);
        if ($urandom_range(0, 1))
            return 8'(TTOI_CH_UA + v - 10);
        return 8'(TTOI_CH_LA + v - 10);
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_whitespace_and_sign();
        send_text(" \011\012\013\014\015-123", TTOI_BASE_DEC);
        send_text("+45", TTOI_BASE_DEC);
        send_text("-", TTOI_BASE_DEC);
        send_text("  ", TTOI_BASE_DEC);
        send_text("", TTOI_BASE_DEC);
    endtask

    task automatic test_prefixes();
        send_text("0x1aF!", TTOI_BASE_AUTO);
        send_text("0X7f", TTOI_BASE_HEX);
        send_text("0777", TTOI_BASE_AUTO);
        send_text("09", TTOI_BASE_AUTO);
        send_text("0x", TTOI_BASE_AUTO);
        send_text("0xg", TTOI_BASE_HEX);
        send_text("012", TTOI_BASE_DEC);
    endtask

    task automatic test_digit_bases();
        send_text("AZaz", 6'd36);
        send_text("001", 6'd1);
        send_text("1012", 6'd2);
        send_text("zZ$", 6'd63);
        send_text("Z", 6'd35);
    endtask

    task automatic test_overflow_wrap();
        send_text("9223372036854775807", TTOI_BASE_DEC);
        send_text("-9223372036854775808", TTOI_BASE_DEC);
        send_text("zzzzzzzzzzzzzz", 6'd36);
    endtask

    task automatic test_abort_and_stray();
        send_char("7", 1'b0, TTOI_BASE_DEC);
        send_char(8'h00, 1'b0, TTOI_BASE_DEC);
        send_char("1", 1'b1, TTOI_BASE_DEC);
        send_char("2", 1'b0, TTOI_BASE_DEC);
        send_char("4", 1'b1, TTOI_BASE_HEX);
        send_char("f", 1'b0, TTOI_BASE_DEC);
        send_char(8'hFF, 1'b0, TTOI_BASE_DEC);
        send_char(8'hFF, 1'b0, TTOI_BASE_DEC);
    endtask

    task automatic test_count_saturation();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_char(TTOI_CH_SPACE, 1'b1, TTOI_BASE_DEC);
        repeat (int'(COUNT_CAP) + 64) send_char(TTOI_CH_SPACE, 1'b0, TTOI_BASE_DEC);
        send_char("4", 1'b0, TTOI_BASE_DEC);
        send_char("2", 1'b0, TTOI_BASE_DEC);
        send_char(8'h00, 1'b0, TTOI_BASE_DEC);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_backpressure();
        tx_idle   = 1'b0;
        hold_left = 400;
        for (int i = 0; i < 40; i++)
            send_text("-5", TTOI_BASE_DEC);
        tx_idle = 1'b1;
    endtask

    task automatic random_conversion();
        logic [5:0] b;
        int         eff;
        int         sel;
        int         ndig;
        int         w;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: b = TTOI_BASE_AUTO;
            3:       b = TTOI_BASE_DEC;
            4:       b = TTOI_BASE_HEX;
            5:       b = TTOI_BASE_OCT;
            6:       b = 6'd2;
            7:       b = 6'd36;
            default: b = 6'($urandom_range(1, 63));
        endcase
        eff = int'(b);
        lead_flag = 1'b1;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
            begin
                w = $urandom_range(8, 13);
                emit(w == 8 ? TTOI_CH_SPACE : 8'(w), b);
            end
        case ($urandom_range(0, 2))
            1: emit(TTOI_CH_PLUS, b);
            2: emit(TTOI_CH_MINUS, b);
            default: ;
        endcase
        if (b == TTOI_BASE_AUTO)
        begin
            sel = $urandom_range(0, 2);
            eff = (sel == 0) ? 16 : (sel == 1) ? 8 : 10;
            if (sel != 2)
                emit(TTOI_CH_0, b);
            if (sel == 0)
                emit($urandom_range(0, 1) ? TTOI_CH_UX : TTOI_CH_LX, b);
        end
        else if (b == TTOI_BASE_HEX && $urandom_range(0, 1))
        begin
            emit(TTOI_CH_0, b);
            emit($urandom_range(0, 1) ? TTOI_CH_UX : TTOI_CH_LX, b);
        end
        ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
        repeat (ndig)
            emit(digit_char($urandom_range(0, (eff > 36 ? 36 : eff) - 1)), b);
        emit(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255)), b);
    endtask

    task automatic test_random_text();
        int stop_at;
        stop_at = chars_sent + RANDOM_CHARS;
        while (chars_sent < stop_at)
        begin
            if ($urandom_range(0, 39) == 0)
                tx_idle = !tx_idle;
            if ($urandom_range(0, 39) == 0)
                rx_idle = !rx_idle;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4))
                    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                              6'($urandom_range(0, 63)));
            else
                random_conversion();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_whitespace_and_sign();
        test_prefixes();
        test_digit_bases();
        test_overflow_wrap();
        test_abort_and_stray();
        test_count_saturation();
        test_backpressure();
        test_random_text();
        drain();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
            report("missing requests", 64'(pending_results.size()), 64'd0);
        $display("Sent %0d characters; %0d conversion results compared, %0d overflowed.",
                 chars_sent, results_seen, ovf_seen);
        $display("Whitespace, signs, prefixes, bases 1..63, aborts, count limit %0d, %s",
                 COUNT_CAP, "long output hold-off all exercised.");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
